FILE: src/psfp_pkg.sv
// Package for the pump status frame parser: framing constants, kind codes,
// status codes and the structs passed between the framer, the classifier and the top level.
// Depends on nothing.
package psfp_pkg;

  localparam int ByteW   = 8;
  localparam int LenW    = 9;
  localparam int ValueW  = 16;
  localparam int NumW    = 32;
  localparam int KindW   = 2;

  // Framing constants.
  localparam logic [ByteW-1:0] START_BYTE    = 8'h24;
  localparam logic [LenW-1:0]  LENGTH_OFFSET = 9'd4;
  localparam logic [LenW-1:0]  LENGTH_POS    = 9'd1;
  localparam logic [LenW-1:0]  KIND_POS      = 9'd8;
  localparam logic [LenW-1:0]  LOW_POS       = 9'd13;
  localparam logic [LenW-1:0]  HIGH_POS      = 9'd14;

  // Frame classes.
  localparam logic [LenW-1:0]  STATUS_LEN      = 9'd22;
  localparam logic [ByteW-1:0] STATUS_MARK     = 8'h2F;
  localparam logic [LenW-1:0]  VALUE_FRAME_LEN = 9'd26;
  localparam logic [ByteW-1:0] VALUE_MARK      = 8'hA4;

  localparam logic [KindW-1:0] KIND_OTHER    = 2'd0;
  localparam logic [KindW-1:0] KIND_STATUS   = 2'd1;
  localparam logic [KindW-1:0] KIND_VALUE    = 2'd2;

  // Status codes, written as {high byte, low byte}.
  localparam logic [ValueW-1:0] CODE_RUNNING = 16'h0001;
  localparam logic [ValueW-1:0] CODE_IDLE_ON = 16'h016D;
  localparam logic [ValueW-1:0] CODE_MANUAL  = 16'h0101;
  localparam logic [ValueW-1:0] CODE_DRY     = 16'h0108;

  // A completed frame as the framer sees it.
  typedef struct packed {
    logic             done;
    logic [LenW-1:0]  length;
    logic [ByteW-1:0] kind_byte;
    logic [ByteW-1:0] low_byte;
    logic [ByteW-1:0] high_byte;
    logic [NumW-1:0]  number;
  } frame_t;

  // One decoded result word.
  typedef struct packed {
    logic [KindW-1:0]  frame_kind;
    logic [LenW-1:0]   frame_length;
    logic [ValueW-1:0] field_value;
    logic              state_known;
    logic              pump_running;
    logic              water_missing;
    logic              stopped_by_hand;
    logic              control_enabled;
    logic [NumW-1:0]   frame_number;
  } result_t;

endpackage

FILE: src/psfp_framer.sv
// Framer for the pump status frame parser: hunts for the start byte, counts bytes,
// captures the length, kind and value bytes and the running frame count.
// Depends on psfp_pkg.
module psfp_framer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [psfp_pkg::ByteW-1:0]  rx_byte,
  input  logic                        drop_partial,
  output psfp_pkg::frame_t            frame
);
  import psfp_pkg::*;

  logic              in_frame, in_frame_next;
  logic [LenW-1:0]   byte_count, byte_count_next;
  logic [LenW-1:0]   expected_length, expected_length_next;
  logic [ByteW-1:0]  kind_byte, kind_byte_next;
  logic [ByteW-1:0]  low_byte, low_byte_next;
  logic [ByteW-1:0]  high_byte, high_byte_next;
  logic [NumW-1:0]   frame_counter, frame_counter_next;
  logic [LenW-1:0]   count_inc;
  logic              done;

  assign count_inc = byte_count + 9'd1;

  always_comb begin
    in_frame_next        = in_frame;
    byte_count_next      = byte_count;
    expected_length_next = expected_length;
    kind_byte_next       = kind_byte;
    low_byte_next        = low_byte;
    high_byte_next       = high_byte;
    frame_counter_next   = frame_counter;
    done                 = 1'b0;
    if (step) begin
      if (drop_partial) begin
        in_frame_next        = 1'b0;
        byte_count_next      = '0;
        expected_length_next = '0;
      end else if (!in_frame) begin
        if (rx_byte == START_BYTE) begin
          in_frame_next        = 1'b1;
          byte_count_next      = LENGTH_POS;
          expected_length_next = '0;
          kind_byte_next       = '0;
          low_byte_next        = '0;
          high_byte_next       = '0;
        end
      end else begin
        byte_count_next = count_inc;
        case (byte_count)
          LENGTH_POS: expected_length_next = {1'b0, rx_byte} + LENGTH_OFFSET;
          KIND_POS:   kind_byte_next       = rx_byte;
          LOW_POS:    low_byte_next        = rx_byte;
          HIGH_POS:   high_byte_next       = rx_byte;
          default:    ;
        endcase
        if (expected_length_next != '0 && count_inc == expected_length_next) begin
          done                 = 1'b1;
          frame_counter_next   = frame_counter + 32'd1;
          in_frame_next        = 1'b0;
          byte_count_next      = '0;
          expected_length_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      byte_count      <= '0;
      expected_length <= '0;
      kind_byte       <= '0;
      low_byte        <= '0;
      high_byte       <= '0;
      frame_counter   <= '0;
    end else begin
      in_frame        <= in_frame_next;
      byte_count      <= byte_count_next;
      expected_length <= expected_length_next;
      kind_byte       <= kind_byte_next;
      low_byte        <= low_byte_next;
      high_byte       <= high_byte_next;
      frame_counter   <= frame_counter_next;
    end
  end

  // The completed frame includes the byte that closes it.
  always_comb begin
    frame.done      = done;
    frame.length    = count_inc;
    frame.kind_byte = kind_byte_next;
    frame.low_byte  = low_byte_next;
    frame.high_byte = high_byte_next;
    frame.number    = frame_counter_next;
  end

endmodule

FILE: src/psfp_classify.sv
// Classifier for the pump status frame parser: sorts a completed frame into
// other, status or value, and decodes the status code into pump flags.
// Depends on psfp_pkg.
module psfp_classify (
  input  psfp_pkg::frame_t   frame,
  output psfp_pkg::result_t  result
);
  import psfp_pkg::*;

  logic [ValueW-1:0] code;
  logic              is_status;
  logic              is_value;

  assign code      = {frame.high_byte, frame.low_byte};
  assign is_status = (frame.length == STATUS_LEN) && (frame.kind_byte == STATUS_MARK);
  assign is_value  = (frame.length == VALUE_FRAME_LEN) && (frame.kind_byte == VALUE_MARK);

  always_comb begin
    result                 = '0;
    result.frame_length    = frame.length;
    result.frame_number    = frame.number;
    if (is_status) begin
      result.frame_kind  = KIND_STATUS;
      result.field_value = code;
      case (code)
        CODE_RUNNING: begin
          result.state_known     = 1'b1;
          result.pump_running    = 1'b1;
          result.control_enabled = 1'b1;
        end
        CODE_IDLE_ON: begin
          result.state_known     = 1'b1;
          result.control_enabled = 1'b1;
        end
        CODE_MANUAL: begin
          result.state_known     = 1'b1;
          result.stopped_by_hand = 1'b1;
        end
        CODE_DRY: begin
          result.state_known     = 1'b1;
          result.water_missing   = 1'b1;
          result.control_enabled = 1'b1;
        end
        default: ;
      endcase
    end else if (is_value) begin
      result.frame_kind  = KIND_VALUE;
      result.field_value = code;
    end else begin
      result.frame_kind  = KIND_OTHER;
    end
  end

endmodule

FILE: src/pump_status_frame_parser.sv
// Top level of the pump status frame parser: input register, framer, classifier
// and result register.
// Depends on psfp_pkg, psfp_framer and psfp_classify.
//
//   Channel | Handshake           | Word carries
//   --------+---------------------+----------------------------------------------
//   in      | in_valid / in_stall | rx_byte, drop_partial
//   out     | out_valid/out_stall | frame_kind, frame_length, field_value, flags,
//           |                     | frame_number
//
// One byte is accepted every cycle while in_stall is low. A byte taken sits in the input
// register until the result register is free, is then parsed, and a frame it completes
// is written into the result register. Reset (rst, synchronous) empties both registers
// and sends the framer back to hunting with a zero frame counter.
// in_stall rises only while the input register holds a byte and a result waits
// under out_stall; the framer state then holds until the result is taken.
module pump_status_frame_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [psfp_pkg::ByteW-1:0]    rx_byte,
  input  logic                          drop_partial,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [psfp_pkg::KindW-1:0]    frame_kind,
  output logic [psfp_pkg::LenW-1:0]     frame_length,
  output logic [psfp_pkg::ValueW-1:0]   field_value,
  output logic                          state_known,
  output logic                          pump_running,
  output logic                          water_missing,
  output logic                          stopped_by_hand,
  output logic                          control_enabled,
  output logic [psfp_pkg::NumW-1:0]     frame_number
);
  import psfp_pkg::*;

  // Input register.
  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             s1_drop;

  // Result register.
  logic             res_valid;
  result_t          res;

  logic             res_free;
  logic             s1_fire;
  logic             in_fire;
  frame_t           frame;
  result_t          result;

  // The result register can take a new word when it is empty or being drained.
  assign res_free = !res_valid || !out_stall;
  assign s1_fire  = s1_valid && res_free;
  assign in_stall = s1_valid && !res_free;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte <= rx_byte;
      s1_drop <= drop_partial;
    end
  end

  psfp_framer u_framer (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_fire),
    .rx_byte      (s1_byte),
    .drop_partial (s1_drop),
    .frame        (frame)
  );

  psfp_classify u_classify (
    .frame  (frame),
    .result (result)
  );

  // frame.done is only high on a parsing step, which needs res_free.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= frame.done;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.done) begin
      res <= result;
    end
  end

  assign out_valid       = res_valid;
  assign frame_kind      = res.frame_kind;
  assign frame_length    = res.frame_length;
  assign field_value     = res.field_value;
  assign state_known     = res.state_known;
  assign pump_running    = res.pump_running;
  assign water_missing   = res.water_missing;
  assign stopped_by_hand = res.stopped_by_hand;
  assign control_enabled = res.control_enabled;
  assign frame_number    = res.frame_number;

  // Pump flags only appear on status frames with a recognized code.
  a_flags_need_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && (state_known || pump_running || water_missing || stopped_by_hand)
      |-> frame_kind == KIND_STATUS && state_known)
    else $error("pump flags set outside a known status frame");

  // At most one of the exclusive status flags is set.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot0({pump_running, water_missing, stopped_by_hand}))
    else $error("more than one exclusive status flag set");

  // Control is enabled only for a known code that is not a manual stop.
  a_control_rule: assert property (@(posedge clk) disable iff (rst)
    res_valid && control_enabled |-> state_known && !stopped_by_hand)
    else $error("control_enabled inconsistent with status code");

  // Class lengths match the frame length.
  a_kind_length: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (frame_kind != KIND_VALUE || frame_length == VALUE_FRAME_LEN) &&
                  (frame_kind != KIND_STATUS || frame_length == STATUS_LEN))
    else $error("frame kind does not match its length");

  // Successive frames carry consecutive numbers.
  a_number_steps: assert property (@(posedge clk) disable iff (rst)
    frame.done && res_free && $past(frame.done && res_free && !rst)
      |-> frame.number == $past(frame.number) + 32'd1)
    else $error("frame counter did not advance by one");

endmodule

FILE: test/pump_status_frame_parser_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for pump_status_frame_parser: a directed frame table, then random
// frames, drops and noise, with a byte-by-byte parser model in the bench checking every word.
// Depends on psfp_pkg and the pump_status_frame_parser RTL.
module pump_status_frame_parser_test;
  import psfp_pkg::*;

  // Run sizing. RANDOM_WORDS counts only bytes that belong to frames; noise is extra.
  localparam int RANDOM_WORDS = 750;
  localparam int QUIET_WORDS  = 150;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int CYCLE_LIMIT  = 500000;

  // Length bytes that make the two recognized frame sizes.
  localparam logic [ByteW-1:0] STATUS_LEN_BYTE      = 8'(STATUS_LEN - LENGTH_OFFSET);
  localparam logic [ByteW-1:0] VALUE_FRAME_LEN_BYTE = 8'(VALUE_FRAME_LEN - LENGTH_OFFSET);

  // An all-zero result never occurs (every frame is at least four bytes), so it marks
  // "no hand-written expectation for this word".
  localparam result_t NO_FRAME = '0;

  // One line of the directed table. For frame rows, b is the length byte; for single
  // words it is the byte itself. A cut row sends only the first cut bytes of the frame
  // and then a drop word.
  typedef enum logic [1:0] {
    ROW_WORD,
    ROW_FRAME,
    ROW_CUT
  } row_op_e;

  typedef struct {
    row_op_e          op;
    logic [ByteW-1:0] b;
    logic             drop;
    logic [ByteW-1:0] mark;
    logic [15:0]      code;
    logic [ByteW-1:0] fill;
    int               cut;
    result_t          want;
  } row_t;

  logic clk;
  logic rst = 1'b1;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ByteW-1:0]  rx_byte = '0;
  logic              drop_partial = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [KindW-1:0]  frame_kind;
  logic [LenW-1:0]   frame_length;
  logic [ValueW-1:0] field_value;
  logic              state_known;
  logic              pump_running;
  logic              water_missing;
  logic              stopped_by_hand;
  logic              control_enabled;
  logic [NumW-1:0]   frame_number;

  pump_status_frame_parser uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .rx_byte         (rx_byte),
    .drop_partial    (drop_partial),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .frame_kind      (frame_kind),
    .frame_length    (frame_length),
    .field_value     (field_value),
    .state_known     (state_known),
    .pump_running    (pump_running),
    .water_missing   (water_missing),
    .stopped_by_hand (stopped_by_hand),
    .control_enabled (control_enabled),
    .frame_number    (frame_number)
  );

  // Decoded frames the block still owes us, oldest first.
  result_t expected_frames[$];

  // The directed table, in the order it is sent.
  row_t rows[$];

  // Bench-side copy of the parser state. It starts out as the block does after reset.
  logic              open_frame    = 1'b0;
  logic [LenW-1:0]   byte_pos      = '0;
  logic [LenW-1:0]   frame_len_due = '0;
  logic [ByteW-1:0]  kind_seen     = '0;
  logic [ByteW-1:0]  low_seen      = '0;
  logic [ByteW-1:0]  high_seen     = '0;
  logic [NumW-1:0]   frames_parsed = '0;

  int  mismatches   = 0;
  int  words_sent   = 0;
  int  frame_words  = 0;
  int  drops_sent   = 0;
  int  results_seen = 0;
  int  status_seen  = 0;
  int  value_seen   = 0;
  int  cycles       = 0;
  bit  quiet        = 1'b0;
  bit  gappy        = 1'b1;
  bit  held_long    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset is held at the start and never raised again.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("pump_status_frame_parser_test: FAIL");
      $finish;
    end
  end

  // Appends one line to the directed table.
  function automatic void add_row(input row_t r);
    rows.insert(rows.size(), r);
  endfunction

  // Hand-written expectation. Flags are packed as {known, running, dry, manual, enabled}.
  function automatic result_t decoded(input logic [KindW-1:0] kind, input int len,
                                      input logic [ValueW-1:0] value, input logic [4:0] flags,
                                      input int num);
    result_t r;
    r.frame_kind      = kind;
    r.frame_length    = LenW'(len);
    r.field_value     = value;
    r.state_known     = flags[4];
    r.pump_running    = flags[3];
    r.water_missing   = flags[2];
    r.stopped_by_hand = flags[1];
    r.control_enabled = flags[0];
    r.frame_number    = NumW'(num);
    return r;
  endfunction

  // Feeds one accepted word through the bench's parser. When the word closes a frame,
  // done is set and r holds the decoded frame with the updated frame count.
  task automatic parse_byte(input logic [ByteW-1:0] b, input logic drop,
                            output bit done, output result_t r);
    logic [LenW-1:0]   pos;
    logic [ValueW-1:0] code;
    done = 1'b0;
    r    = NO_FRAME;
    // A drop abandons whatever frame is open but leaves the frame count alone.
    if (drop) begin
      open_frame    = 1'b0;
      byte_pos      = '0;
      frame_len_due = '0;
      return;
    end
    // While hunting, everything but the start byte is thrown away.
    if (!open_frame) begin
      if (b == START_BYTE) begin
        open_frame    = 1'b1;
        byte_pos      = 9'd1;
        frame_len_due = '0;
        kind_seen     = '0;
        low_seen      = '0;
        high_seen     = '0;
      end
      return;
    end
    // Inside a frame every byte is data, the start byte included.
    pos      = byte_pos;
    byte_pos = byte_pos + 9'd1;
    if (pos == LENGTH_POS) frame_len_due = {1'b0, b} + LENGTH_OFFSET;
    else if (pos == KIND_POS) kind_seen = b;
    else if (pos == LOW_POS) low_seen = b;
    else if (pos == HIGH_POS) high_seen = b;
    if (frame_len_due != '0 && byte_pos == frame_len_due) begin
      frames_parsed  = frames_parsed + 1;
      code           = {high_seen, low_seen};
      r.frame_length = byte_pos;
      r.frame_number = frames_parsed;
      if (byte_pos == STATUS_LEN && kind_seen == STATUS_MARK) begin
        r.frame_kind      = KIND_STATUS;
        r.field_value     = code;
        r.pump_running    = (code == CODE_RUNNING);
        r.water_missing   = (code == CODE_DRY);
        r.stopped_by_hand = (code == CODE_MANUAL);
        r.state_known     = r.pump_running || r.water_missing || r.stopped_by_hand ||
                            (code == CODE_IDLE_ON);
        // Control counts as enabled for every recognized code except a manual stop.
        r.control_enabled = r.state_known && !r.stopped_by_hand;
      end else if (byte_pos == VALUE_FRAME_LEN && kind_seen == VALUE_MARK) begin
        r.frame_kind  = KIND_VALUE;
        r.field_value = code;
      end else begin
        r.frame_kind = KIND_OTHER;
      end
      done          = 1'b1;
      open_frame    = 1'b0;
      byte_pos      = '0;
      frame_len_due = '0;
    end
  endtask

  // Offers one word and returns at the edge that takes it. Valid is raised without
  // looking at in_stall, and the payload stays put until the word is taken. While the
  // sender is in its gappy mood it may first sit idle for a burst of cycles.
  task automatic send_word(input logic [ByteW-1:0] b, input logic d, input result_t want);
    int      gap;
    bit      done;
    result_t r;
    gap = 0;
    if ($urandom_range(0, 63) == 0) gappy = !gappy;
    if (!quiet && gappy && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    rx_byte      <= b;
    drop_partial <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (d) drops_sent++;
    // A hand-written row's expectation stands in for the model's answer on that word;
    // the model still runs so that its state stays in step with the block.
    parse_byte(b, d, done, r);
    if (want != NO_FRAME) expected_frames.insert(expected_frames.size(), want);
    else if (done) expected_frames.insert(expected_frames.size(), r);
  endtask

  // Sends a frame built from its header fields. With cut above zero only the first cut
  // bytes go out, followed by a drop word; want applies to the closing byte only.
  task automatic send_frame(input logic [ByteW-1:0] len_byte, input logic [ByteW-1:0] mark,
                            input logic [ValueW-1:0] code, input logic [ByteW-1:0] fill,
                            input bit rand_fill, input int cut, input result_t want);
    int               total;
    int               stop;
    logic [ByteW-1:0] b;
    total = int'(len_byte) + int'(LENGTH_OFFSET);
    stop  = (cut > 0) ? cut : total;
    for (int pos = 0; pos < stop; pos++) begin
      if (pos == 0) b = START_BYTE;
      else if (pos == int'(LENGTH_POS)) b = len_byte;
      else if (pos == int'(KIND_POS)) b = mark;
      else if (pos == int'(LOW_POS)) b = code[7:0];
      else if (pos == int'(HIGH_POS)) b = code[15:8];
      else if (rand_fill) b = 8'($urandom);
      else b = fill;
      frame_words++;
      send_word(b, 1'b0, (cut == 0 && pos == total - 1) ? want : NO_FRAME);
    end
    if (cut > 0) send_word(8'($urandom), 1'b1, NO_FRAME);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: every word taken from the block is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_frames.size() == 0) begin
        $error("result word with no frame expected (frame_number 0x%0h)", frame_number);
        mismatches++;
      end else begin
        want = expected_frames.pop_front();
        if (want.frame_kind == KIND_STATUS) status_seen++;
        if (want.frame_kind == KIND_VALUE) value_seen++;
        check_field("frame_kind", 32'(want.frame_kind), 32'(frame_kind));
        check_field("frame_length", 32'(want.frame_length), 32'(frame_length));
        check_field("field_value", 32'(want.field_value), 32'(field_value));
        check_field("state_known", 32'(want.state_known), 32'(state_known));
        check_field("pump_running", 32'(want.pump_running), 32'(pump_running));
        check_field("water_missing", 32'(want.water_missing), 32'(water_missing));
        check_field("stopped_by_hand", 32'(want.stopped_by_hand), 32'(stopped_by_hand));
        check_field("control_enabled", 32'(want.control_enabled), 32'(control_enabled));
        check_field("frame_number", 32'(want.frame_number), 32'(frame_number));
      end
    end
  end

  // Receiver: random bursts of stall and no stall. Once a few dozen results have come
  // through it holds off for a long stretch while the sender keeps offering, so the
  // result register fills and the block has to stall its input. Near the end it
  // takes everything at once.
  initial begin : receiver
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!held_long && results_seen >= 30) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        n = $urandom_range(1, 16);
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int                pick;
    int                random_start;
    int                waited;
    int                cut;
    logic [ByteW-1:0]  len_byte;
    logic [ByteW-1:0]  mark;
    logic [ValueW-1:0] code;

    // Directed table. Frame numbers in the typed rows count from reset; rows carrying
    // NO_FRAME are left to the bench's parser.
    // Noise while hunting, and a drop that carries the start byte (must not open a frame).
    add_row('{ROW_WORD, 8'h00, 1'b0, 8'h00, 16'h0000, 8'h00, 0, NO_FRAME});
    add_row('{ROW_WORD, 8'hFF, 1'b0, 8'h00, 16'h0000, 8'h00, 0, NO_FRAME});
    add_row('{ROW_WORD, START_BYTE, 1'b1, 8'h00, 16'h0000, 8'h00, 0, NO_FRAME});
    // Shortest frame: length byte zero, closes on its fourth byte.
    add_row('{ROW_FRAME, 8'h00, 1'b0, 8'h00, 16'h0000, 8'h00, 0,
              decoded(KIND_OTHER, 4, 16'h0000, 5'b00000, 1)});
    // Status frames, one per recognized code, then an unknown one.
    add_row('{ROW_FRAME, STATUS_LEN_BYTE, 1'b0, STATUS_MARK, CODE_RUNNING, 8'h00, 0,
              decoded(KIND_STATUS, 22, CODE_RUNNING, 5'b11001, 2)});
    add_row('{ROW_FRAME, STATUS_LEN_BYTE, 1'b0, STATUS_MARK, CODE_IDLE_ON, 8'hFF, 0,
              decoded(KIND_STATUS, 22, CODE_IDLE_ON, 5'b10001, 3)});
    // Fill with the start byte: it must count as plain data inside the frame.
    add_row('{ROW_FRAME, STATUS_LEN_BYTE, 1'b0, STATUS_MARK, CODE_MANUAL, START_BYTE, 0,
              decoded(KIND_STATUS, 22, CODE_MANUAL, 5'b10010, 4)});
    add_row('{ROW_FRAME, STATUS_LEN_BYTE, 1'b0, STATUS_MARK, CODE_DRY, 8'h5A, 0,
              decoded(KIND_STATUS, 22, CODE_DRY, 5'b10101, 5)});
    add_row('{ROW_FRAME, STATUS_LEN_BYTE, 1'b0, STATUS_MARK, 16'hFFFF, 8'hA5, 0,
              decoded(KIND_STATUS, 22, 16'hFFFF, 5'b00000, 6)});
    // Running code with its bytes swapped is not a known state.
    add_row('{ROW_FRAME, STATUS_LEN_BYTE, 1'b0, STATUS_MARK, 16'h0100, 8'h00, 0,
              NO_FRAME});
    // Value frames at both ends of the range and in between.
    add_row('{ROW_FRAME, VALUE_FRAME_LEN_BYTE, 1'b0, VALUE_MARK, 16'h1234, 8'h00, 0,
              decoded(KIND_VALUE, 26, 16'h1234, 5'b00000, 8)});
    add_row('{ROW_FRAME, VALUE_FRAME_LEN_BYTE, 1'b0, VALUE_MARK, 16'hFFFF, 8'h11, 0,
              decoded(KIND_VALUE, 26, 16'hFFFF, 5'b00000, 9)});
    add_row('{ROW_FRAME, VALUE_FRAME_LEN_BYTE, 1'b0, VALUE_MARK, 16'h0000, 8'hEE, 0,
              decoded(KIND_VALUE, 26, 16'h0000, 5'b00000, 10)});
    // Marks paired with the wrong length, and a status mark one byte too long.
    add_row('{ROW_FRAME, STATUS_LEN_BYTE, 1'b0, VALUE_MARK, CODE_RUNNING, 8'h00, 0,
              NO_FRAME});
    add_row('{ROW_FRAME, VALUE_FRAME_LEN_BYTE, 1'b0, STATUS_MARK, CODE_RUNNING, 8'h00, 0,
              NO_FRAME});
    add_row('{ROW_FRAME, STATUS_LEN_BYTE + 8'd1, 1'b0, STATUS_MARK, CODE_RUNNING, 8'h00,
              0, NO_FRAME});
    // A status frame cut off by a drop, then a drop while already hunting.
    add_row('{ROW_CUT, STATUS_LEN_BYTE, 1'b0, STATUS_MARK, CODE_RUNNING, 8'h00, 10,
              NO_FRAME});
    add_row('{ROW_WORD, 8'h01, 1'b1, 8'h00, 16'h0000, 8'h00, 0, NO_FRAME});
    add_row('{ROW_FRAME, 8'h01, 1'b0, 8'h00, 16'h0000, START_BYTE, 0, NO_FRAME});
    // Longest frame, then a long frame dropped right after its length byte.
    add_row('{ROW_FRAME, 8'hFF, 1'b0, 8'h00, 16'h0000, 8'hC3, 0,
              decoded(KIND_OTHER, 259, 16'h0000, 5'b00000, 15)});
    add_row('{ROW_CUT, 8'hFF, 1'b0, 8'h00, 16'h0000, 8'h00, 2, NO_FRAME});
    // The frame count survives the drops.
    add_row('{ROW_FRAME, STATUS_LEN_BYTE, 1'b0, STATUS_MARK, CODE_RUNNING, 8'h3C, 0,
              decoded(KIND_STATUS, 22, CODE_RUNNING, 5'b11001, 16)});

    @(posedge clk iff !rst);
    foreach (rows[i]) begin
      case (rows[i].op)
        ROW_WORD: begin
          send_word(rows[i].b, rows[i].drop, rows[i].want);
        end
        ROW_FRAME: begin
          send_frame(rows[i].b, rows[i].mark, rows[i].code, rows[i].fill, 1'b0, 0,
                     rows[i].want);
        end
        default: begin
          send_frame(rows[i].b, rows[i].mark, rows[i].code, rows[i].fill, 1'b0, rows[i].cut,
                     NO_FRAME);
        end
      endcase
    end

    // Random part. Most traffic is well-formed status and value frames with random
    // contents, since those reach the decode paths; the rest is short odd frames, the
    // occasional long one, frames broken off by a drop, and noise between frames.
    random_start = frame_words;
    while (frame_words - random_start < RANDOM_WORDS) begin
      if (frame_words - random_start > RANDOM_WORDS - QUIET_WORDS) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // Noise between frames. A start byte here would open a frame, so flip it;
        // a drop word may carry anything.
        if (pick < 3) begin
          send_word(8'($urandom), 1'b1, NO_FRAME);
        end else begin
          len_byte = 8'($urandom);
          if (len_byte == START_BYTE) len_byte = ~len_byte;
          send_word(len_byte, 1'b0, NO_FRAME);
        end
      end else if (pick < 45) begin
        case ($urandom_range(0, 5))
          0: code = CODE_RUNNING;
          1: code = CODE_IDLE_ON;
          2: code = CODE_MANUAL;
          3: code = CODE_DRY;
          // Near misses: right high byte, random low byte.
          4: code = {CODE_DRY[15:8], 8'($urandom)};
          default: code = 16'($urandom);
        endcase
        send_frame(STATUS_LEN_BYTE, STATUS_MARK, code, 8'h00, 1'b1, 0, NO_FRAME);
      end else if (pick < 65) begin
        send_frame(VALUE_FRAME_LEN_BYTE, VALUE_MARK, 16'($urandom), 8'h00, 1'b1, 0, NO_FRAME);
      end else if (pick < 85) begin
        case ($urandom_range(0, 3))
          0: mark = STATUS_MARK;
          1: mark = VALUE_MARK;
          default: mark = 8'($urandom);
        endcase
        send_frame(8'($urandom_range(0, 30)), mark, 16'($urandom), 8'h00, 1'b1, 0,
                   NO_FRAME);
      end else if (pick < 88) begin
        send_frame(8'($urandom), 8'($urandom), 16'($urandom), 8'h00, 1'b1, 0, NO_FRAME);
      end else begin
        len_byte = 8'($urandom_range(0, 40));
        cut      = $urandom_range(1, int'(len_byte) + int'(LENGTH_OFFSET) - 1);
        send_frame(len_byte, STATUS_MARK, 16'($urandom), 8'h00, 1'b1, cut, NO_FRAME);
      end
    end
    quiet = 1'b1;
    in_valid <= 1'b0;

    // Let the block catch up, then give it a few more cycles to show any stray word.
    waited = 0;
    while (expected_frames.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_frames.size() != 0) begin
      $error("%0d expected frames never came out", expected_frames.size());
      mismatches++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words (%0d drops); checked %0d frames: %0d status, %0d value.",
             words_sent, drops_sent, results_seen, status_seen, value_seen);
    $display("Receiver held off %0d cycles once; %0d mismatches in %0d cycles.",
             LONG_HOLD, mismatches, cycles);
    if (mismatches == 0) begin
      $display("pump_status_frame_parser_test: PASS");
    end else begin
      $display("pump_status_frame_parser_test: FAIL");
    end
    $finish;
  end

endmodule
